// ===== design/tct_pkg.sv =====
// shared types and codes for the task control table
package tct_pkg;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_CREATE   = 3'd1,
      CMD_DELETE   = 3'd2,
      CMD_DELAY    = 3'd3,
      CMD_SUSPEND  = 3'd4,
      CMD_RESUME   = 3'd5,
      CMD_SET_PRIO = 3'd6,
      CMD_QUERY    = 3'd7
   } cmd_type;

   localparam logic [1:0] ST_CLEARED   = 2'd0;
   localparam logic [1:0] ST_READY     = 2'd1;
   localparam logic [1:0] ST_SLEEPING  = 2'd2;
   localparam logic [1:0] ST_SUSPENDED = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_LIMIT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_PRIO  = 2'd2;

   // one queued command as seen by the back end
   typedef struct packed {
      cmd_type     command;
      logic [3:0]  task_slot;
      logic [7:0]  priority_req;
      logic [31:0] delay_count;
   } cmd_entry_type;

endpackage

// ===== design/task_control_table.sv =====
// task control table: top level
// slot commands pass through the idle, done and output states; tick and create pass through idle, scan and output
// the back end takes a new command only once the previous reply has left, and scans one slot a cycle
// a two-entry queue takes items while the back end is busy
// reset (synchronous, active high) clears every slot and sets the next id to one
module task_control_table #(
   parameter int MAX_TASKS    = 16,
   parameter int MAX_PRIORITY = 31,
   parameter int DELAY_WIDTH  = 32,
   parameter int ID_WIDTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_task_slot,
   input  logic [7:0]  req_priority_req,
   input  logic [31:0] req_delay_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [15:0] rsp_task_id,
   output logic [1:0]  rsp_task_state,
   output logic [7:0]  rsp_task_priority
);
   tct_pkg::cmd_entry_type req_entry, q_entry;
   logic q_valid, q_take;

   assign req_entry.command = tct_pkg::cmd_type'(req_command);
   assign req_entry.task_slot = req_task_slot;
   assign req_entry.priority_req = req_priority_req;
   assign req_entry.delay_count = req_delay_count;

   tct_front #(.DEPTH(2)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_entry,
      .q_valid, .q_take, .q_entry
   );

   tct_back #(
      .MAX_TASKS(MAX_TASKS), .MAX_PRIORITY(MAX_PRIORITY),
      .DELAY_WIDTH(DELAY_WIDTH), .ID_WIDTH(ID_WIDTH)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_entry,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_result_slot,
      .rsp_task_id, .rsp_task_state, .rsp_task_priority
   );
endmodule

// ===== design/tct_front.sv =====
// front end: accepts commands into a short queue
module tct_front #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tct_pkg::cmd_entry_type req_entry,
   output logic                   q_valid,
   input  logic                   q_take,
   output tct_pkg::cmd_entry_type q_entry
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   tct_pkg::cmd_entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_entry = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= req_entry;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop of empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
`endif
endmodule

// ===== design/tct_back.sv =====
// back end: executes commands against the slot table, one slot a cycle for scans
module tct_back #(
   parameter int MAX_TASKS    = 16,
   parameter int MAX_PRIORITY = 31,
   parameter int DELAY_WIDTH  = 32,
   parameter int ID_WIDTH     = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_take,
   input  tct_pkg::cmd_entry_type q_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_result_slot,
   output logic [15:0]            rsp_task_id,
   output logic [1:0]             rsp_task_state,
   output logic [7:0]             rsp_task_priority
);
   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DONE = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [MAX_TASKS-1:0]   used_ff;
   logic [1:0]             state_ff [MAX_TASKS];
   logic [DELAY_WIDTH-1:0] delay_ff [MAX_TASKS];
   logic [7:0]             prio_ff  [MAX_TASKS];
   logic [ID_WIDTH-1:0]    id_ff    [MAX_TASKS];
   logic [ID_WIDTH-1:0]    next_id_ff;
   tct_pkg::cmd_entry_type cmd_ff;
   logic [SW-1:0]          idx_ff;
   logic [SW:0]            full_slot;
   logic                   inrange;
   logic [1:0]             stat_ff;
   logic [3:0]             rslot_ff;
   logic [15:0]            rid_ff;
   logic [1:0]             rst_ff;
   logic [7:0]             rprio_ff;
   logic                   last;

   assign full_slot = (SW+1)'(cmd_ff.task_slot);
   assign inrange = (SW+1+4)'(cmd_ff.task_slot) < (SW+1+4)'(MAX_TASKS);
   assign last = (idx_ff == SW'(MAX_TASKS-1));
   assign q_take = (st_ff == S_IDLE) && q_valid;
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_status = stat_ff;
   assign rsp_result_slot = rslot_ff;
   assign rsp_task_id = rid_ff;
   assign rsp_task_state = rst_ff;
   assign rsp_task_priority = rprio_ff;

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid) begin
            st_in = (q_entry.command == tct_pkg::CMD_TICK ||
                     q_entry.command == tct_pkg::CMD_CREATE) ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            if (cmd_ff.command == tct_pkg::CMD_CREATE && !used_ff[idx_ff]) st_in = S_OUT;
            else if (last) st_in = (cmd_ff.command == tct_pkg::CMD_CREATE) ? S_OUT : S_OUT;
         end
         S_DONE: st_in = S_OUT;
         S_OUT: if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end

   // table and result datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         next_id_ff <= ID_WIDTH'(1);
         for (int i = 0; i < MAX_TASKS; i++) begin
            state_ff[i] <= tct_pkg::ST_CLEARED;
            delay_ff[i] <= '0;
            prio_ff[i] <= '0;
            id_ff[i] <= '0;
         end
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               cmd_ff <= q_entry;
               idx_ff <= '0;
               stat_ff <= tct_pkg::STATUS_OK;
               rslot_ff <= '0;
               rid_ff <= '0;
               rst_ff <= '0;
               rprio_ff <= '0;
            end
            S_SCAN: begin
               if (cmd_ff.command == tct_pkg::CMD_TICK) begin
                  if (used_ff[idx_ff] && state_ff[idx_ff] == tct_pkg::ST_SLEEPING &&
                      delay_ff[idx_ff] != '0) begin
                     delay_ff[idx_ff] <= delay_ff[idx_ff] - 1'b1;
                     if (delay_ff[idx_ff] == DELAY_WIDTH'(1))
                        state_ff[idx_ff] <= tct_pkg::ST_READY;
                  end
               end else if (!used_ff[idx_ff]) begin
                  used_ff[idx_ff] <= 1'b1;
                  id_ff[idx_ff] <= next_id_ff;
                  next_id_ff <= next_id_ff + 1'b1;
                  prio_ff[idx_ff] <= cmd_ff.priority_req;
                  state_ff[idx_ff] <= tct_pkg::ST_READY;
                  delay_ff[idx_ff] <= '0;
                  rslot_ff <= 4'(idx_ff);
                  rid_ff <= 16'(next_id_ff);
                  rst_ff <= tct_pkg::ST_READY;
                  rprio_ff <= cmd_ff.priority_req;
               end else if (last) begin
                  stat_ff <= tct_pkg::STATUS_LIMIT;
               end
               if (!last) idx_ff <= idx_ff + 1'b1;
            end
            S_DONE: begin
               rslot_ff <= cmd_ff.task_slot;
               if (inrange) begin : exec
                  logic [SW-1:0] s;
                  logic [1:0] ns;
                  logic [7:0] np;
                  logic bad;
                  s = SW'(full_slot);
                  ns = state_ff[s];
                  np = prio_ff[s];
                  bad = 1'b0;
                  case (cmd_ff.command)
                     tct_pkg::CMD_DELETE: begin
                        used_ff[s] <= 1'b0;
                        delay_ff[s] <= '0;
                        id_ff[s] <= '0;
                        ns = tct_pkg::ST_CLEARED;
                        np = '0;
                     end
                     tct_pkg::CMD_DELAY: if (used_ff[s]) begin
                        delay_ff[s] <= DELAY_WIDTH'(cmd_ff.delay_count);
                        ns = tct_pkg::ST_SLEEPING;
                     end
                     tct_pkg::CMD_SUSPEND: if (used_ff[s]) ns = tct_pkg::ST_SUSPENDED;
                     tct_pkg::CMD_RESUME:
                        if (used_ff[s] && ns == tct_pkg::ST_SUSPENDED) ns = tct_pkg::ST_READY;
                     tct_pkg::CMD_SET_PRIO: if (used_ff[s]) begin
                        if (32'(cmd_ff.priority_req) > 32'(MAX_PRIORITY)) bad = 1'b1;
                        else np = cmd_ff.priority_req;
                     end
                     default: ;
                  endcase
                  state_ff[s] <= ns;
                  prio_ff[s] <= np;
                  stat_ff <= bad ? tct_pkg::STATUS_BAD_PRIO : tct_pkg::STATUS_OK;
                  rst_ff <= ns;
                  rprio_ff <= np;
                  rid_ff <= (cmd_ff.command == tct_pkg::CMD_DELETE) ? '0 : 16'(id_ff[s]);
               end
            end
            S_OUT: ;
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |=> st_ff != S_IDLE) else $error("take while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status) && $stable(rid_ff))
      else $error("result changed under stall");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("state not one-hot");
`endif
endmodule

// ===== test/task_control_table_test.sv =====
// testbench for the task control table: directed table plus random commands
module task_control_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   localparam int PRIO_LIMIT = 31;
   localparam int RANDOM_ITEMS = 1930;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  result_slot;
      logic [15:0] task_id;
      logic [1:0]  task_state;
      logic [7:0]  task_priority;
   } reply_type;

   typedef struct {
      tct_pkg::cmd_type command;
      logic [3:0]  task_slot;
      logic [7:0]  priority_req;
      logic [31:0] delay_count;
      bit          typed;
      reply_type   reply;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = '0;
   logic [3:0] req_task_slot = '0;
   logic [7:0] req_priority_req = '0;
   logic [31:0] req_delay_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_result_slot;
   logic [15:0] rsp_task_id;
   logic [1:0] rsp_task_state;
   logic [7:0] rsp_task_priority;

   task_control_table u_top (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted table contents
   bit          used_q [SLOTS];
   logic [1:0]  state_q [SLOTS];
   logic [31:0] sleep_q [SLOTS];
   logic [7:0]  prio_q [SLOTS];
   logic [15:0] id_q [SLOTS];
   logic [15:0] next_id_q;

   reply_type pending_replies[$];
   int errors = 0;
   int replies_seen = 0;
   int send_idle = 28, recv_idle = 69;
   row_type rows[$];

   function automatic void clear_entry(int s);
      used_q[s] = 0; state_q[s] = tct_pkg::ST_CLEARED; sleep_q[s] = '0;
      prio_q[s] = '0; id_q[s] = '0;
   endfunction

   function automatic reply_type slot_reply(logic [1:0] st, int s);
      reply_type r;
      r.status = st; r.result_slot = s[3:0];
      r.task_id = id_q[s]; r.task_state = state_q[s]; r.task_priority = prio_q[s];
      return r;
   endfunction

   // apply one command to the predicted table, return its reply
   function automatic reply_type run_command(tct_pkg::cmd_type c, logic [3:0] s,
                                             logic [7:0] p, logic [31:0] d);
      reply_type r;
      logic [1:0] st;
      r = '{default: '0};
      st = tct_pkg::STATUS_OK;
      case (c)
         tct_pkg::CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++)
               if (used_q[i] && state_q[i] == tct_pkg::ST_SLEEPING && sleep_q[i] != 0) begin
                  sleep_q[i]--;
                  if (sleep_q[i] == 0) state_q[i] = tct_pkg::ST_READY;
               end
            return r;
         end
         tct_pkg::CMD_CREATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (!used_q[i]) begin
                  clear_entry(i);
                  used_q[i] = 1; id_q[i] = next_id_q; next_id_q++;
                  prio_q[i] = p; state_q[i] = tct_pkg::ST_READY;
                  return slot_reply(tct_pkg::STATUS_OK, i);
               end
            r.status = tct_pkg::STATUS_LIMIT;
            return r;
         end
         tct_pkg::CMD_DELETE: clear_entry(s);
         tct_pkg::CMD_DELAY: if (used_q[s]) begin
            sleep_q[s] = d; state_q[s] = tct_pkg::ST_SLEEPING;
         end
         tct_pkg::CMD_SUSPEND: if (used_q[s]) state_q[s] = tct_pkg::ST_SUSPENDED;
         tct_pkg::CMD_RESUME:
            if (used_q[s] && state_q[s] == tct_pkg::ST_SUSPENDED)
               state_q[s] = tct_pkg::ST_READY;
         tct_pkg::CMD_SET_PRIO: if (used_q[s]) begin
            if (p > PRIO_LIMIT) st = tct_pkg::STATUS_BAD_PRIO;
            else prio_q[s] = p;
         end
         default: ;
      endcase
      return slot_reply(st, s);
   endfunction

   // send one item, queue its expected reply
   task automatic send_item(tct_pkg::cmd_type c, logic [3:0] s, logic [7:0] p,
                            logic [31:0] d, bit typed, reply_type want);
      reply_type r;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_command <= c; req_task_slot <= s;
      req_priority_req <= p; req_delay_count <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = run_command(c, s, p, d);
      if (typed) r = want;
      pending_replies.push_back(r);
      @(negedge clock);
   endtask

   // receiver stalls
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   // check each reply against the oldest expectation
   always @(posedge clock) begin
      reply_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $error("unexpected reply item");
            errors++;
         end else begin
            w = pending_replies.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d actual %0d", w.status, rsp_status); errors++;
            end
            if (rsp_result_slot !== w.result_slot) begin
               $error("result_slot: expected %0d actual %0d", w.result_slot,
                      rsp_result_slot); errors++;
            end
            if (rsp_task_id !== w.task_id) begin
               $error("task_id: expected %0d actual %0d", w.task_id, rsp_task_id); errors++;
            end
            if (rsp_task_state !== w.task_state) begin
               $error("task_state: expected %0d actual %0d", w.task_state,
                      rsp_task_state); errors++;
            end
            if (rsp_task_priority !== w.task_priority) begin
               $error("task_priority: expected %0d actual %0d", w.task_priority,
                      rsp_task_priority); errors++;
            end
         end
      end
   end

   function automatic row_type mk(tct_pkg::cmd_type c, logic [3:0] s, logic [7:0] p,
                                  logic [31:0] d, bit typed, logic [1:0] st,
                                  logic [3:0] rs, logic [15:0] id, logic [1:0] ts,
                                  logic [7:0] tp);
      row_type r;
      r.command = c; r.task_slot = s; r.priority_req = p; r.delay_count = d;
      r.typed = typed;
      r.reply = '{status: st, result_slot: rs, task_id: id, task_state: ts,
                  task_priority: tp};
      return r;
   endfunction

   // row checked against the predictor only
   function automatic row_type mkp(tct_pkg::cmd_type c, logic [3:0] s, logic [7:0] p,
                                   logic [31:0] d);
      return mk(c, s, p, d, 0, tct_pkg::STATUS_OK, 0, 0, tct_pkg::ST_CLEARED, 0);
   endfunction

   // random command on a random slot, weighted toward tick, create and delete
   task automatic random_item();
      int k;
      tct_pkg::cmd_type c;
      logic [3:0] s;
      logic [7:0] p;
      logic [31:0] d;
      k = $urandom_range(99);
      if (k < 30) c = tct_pkg::CMD_TICK;
      else if (k < 48) c = tct_pkg::CMD_CREATE;
      else if (k < 56) c = tct_pkg::CMD_DELETE;
      else c = tct_pkg::cmd_type'($urandom_range(7));
      s = 4'($urandom_range(15));
      p = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(PRIO_LIMIT));
      case ($urandom_range(3))
         0: d = $urandom;
         1: d = 0;
         default: d = $urandom_range(6);
      endcase
      send_item(c, s, p, d, 0, '{default: '0});
   endtask

   initial begin
      int n;
      for (int i = 0; i < SLOTS; i++) clear_entry(i);
      next_id_q = 16'd1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows: reset state, extremes and the special cases
      rows.push_back(mk(tct_pkg::CMD_QUERY, 15, 0, 0, 1, tct_pkg::STATUS_OK, 15, 0,
                        tct_pkg::ST_CLEARED, 0));
      rows.push_back(mk(tct_pkg::CMD_TICK, 15, 255, '1, 1, tct_pkg::STATUS_OK, 0, 0,
                        tct_pkg::ST_CLEARED, 0));
      rows.push_back(mk(tct_pkg::CMD_CREATE, 9, 255, '1, 1, tct_pkg::STATUS_OK, 0, 1,
                        tct_pkg::ST_READY, 255));
      rows.push_back(mk(tct_pkg::CMD_CREATE, 0, 0, 0, 1, tct_pkg::STATUS_OK, 1, 2,
                        tct_pkg::ST_READY, 0));
      rows.push_back(mk(tct_pkg::CMD_SET_PRIO, 0, 32, 0, 1, tct_pkg::STATUS_BAD_PRIO, 0, 1,
                        tct_pkg::ST_READY, 255));
      rows.push_back(mk(tct_pkg::CMD_SET_PRIO, 0, 31, 0, 1, tct_pkg::STATUS_OK, 0, 1,
                        tct_pkg::ST_READY, 31));
      rows.push_back(mk(tct_pkg::CMD_SET_PRIO, 5, 200, 0, 1, tct_pkg::STATUS_OK, 5, 0,
                        tct_pkg::ST_CLEARED, 0));
      rows.push_back(mkp(tct_pkg::CMD_DELAY, 0, 0, 2));
      rows.push_back(mkp(tct_pkg::CMD_TICK, 0, 0, 0));
      rows.push_back(mkp(tct_pkg::CMD_TICK, 0, 0, 0));
      rows.push_back(mk(tct_pkg::CMD_QUERY, 0, 0, 0, 1, tct_pkg::STATUS_OK, 0, 1,
                        tct_pkg::ST_READY, 31));
      rows.push_back(mkp(tct_pkg::CMD_DELAY, 1, 0, 0));
      rows.push_back(mkp(tct_pkg::CMD_TICK, 0, 0, 0));
      rows.push_back(mk(tct_pkg::CMD_SUSPEND, 1, 0, 0, 1, tct_pkg::STATUS_OK, 1, 2,
                        tct_pkg::ST_SUSPENDED, 0));
      rows.push_back(mk(tct_pkg::CMD_RESUME, 1, 0, 0, 1, tct_pkg::STATUS_OK, 1, 2,
                        tct_pkg::ST_READY, 0));
      rows.push_back(mkp(tct_pkg::CMD_RESUME, 1, 0, 0));
      rows.push_back(mkp(tct_pkg::CMD_DELAY, 0, 0, '1));
      rows.push_back(mkp(tct_pkg::CMD_SUSPEND, 0, 0, 0));
      rows.push_back(mk(tct_pkg::CMD_DELETE, 1, 0, 0, 1, tct_pkg::STATUS_OK, 1, 0,
                        tct_pkg::ST_CLEARED, 0));
      rows.push_back(mk(tct_pkg::CMD_DELETE, 1, 0, 0, 1, tct_pkg::STATUS_OK, 1, 0,
                        tct_pkg::ST_CLEARED, 0));
      foreach (rows[i])
         send_item(rows[i].command, rows[i].task_slot, rows[i].priority_req,
                   rows[i].delay_count, rows[i].typed, rows[i].reply);
      // fill the table to hit the task limit
      for (int i = 0; i < 16; i++)
         send_item(tct_pkg::CMD_CREATE, 0, 8'(i), 0, 0, '{default: '0});
      send_item(tct_pkg::CMD_CREATE, 0, 7, 0, 1,
                '{tct_pkg::STATUS_LIMIT, 0, 0, tct_pkg::ST_CLEARED, 0});

      // random part in three idling phases
      n = 0;
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle = 69; recv_idle = 28; end
         if (ph == 2) begin send_idle = 0; recv_idle = 0; end
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item();
      end
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d replies over all commands, full table and id wrap-free run",
               replies_seen);
      if (errors == 0 && pending_replies.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== sim.f =====
design/tct_pkg.sv
design/tct_front.sv
design/tct_back.sv
design/task_control_table.sv
test/task_control_table_test.sv
